// ===== hdl/sat_pkg.sv =====
package sat_pkg;

  localparam int MaxStations = 64;
  localparam int IdxW        = (MaxStations > 1) ? $clog2(MaxStations) : 1;
  localparam int CntW        = $clog2(MaxStations + 1);
  localparam int AddrW       = 48;
  localparam int ActionW     = 2;
  localparam int SlotW       = 6;
  localparam int StatusW     = 3;
  localparam int CountW      = 7;

  typedef enum logic [ActionW-1:0] {
    ActLookup = 2'd0,
    ActAdd    = 2'd1,
    ActRemove = 2'd2
  } action_e;

  typedef enum logic [StatusW-1:0] {
    StFound    = 3'd0,
    StAdded    = 3'd1,
    StFull     = 3'd2,
    StNotFound = 3'd3,
    StRemoved  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CtrlIdle   = 2'd0,
    CtrlScan   = 2'd1,
    CtrlFinish = 2'd2
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
  } sat_cmd_t;

  typedef struct packed {
    logic scan_end;
  } sat_stat_t;

endpackage

// ===== hdl/sat_ctrl.sv =====
module sat_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  sat_pkg::sat_stat_t stat_i,
  output sat_pkg::sat_cmd_t  cmd_o,
  output logic               busy_o
);
  import sat_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CtrlIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      CtrlIdle: begin
        if (start_i) begin
          state_d = CtrlScan;
        end
      end
      CtrlScan: begin
        if (stat_i.scan_end) begin
          state_d = CtrlFinish;
        end
      end
      CtrlFinish: begin
        state_d = CtrlIdle;
      end
      default: begin
        state_d = CtrlIdle;
      end
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    case (state_q)
      CtrlIdle: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
      end
      CtrlScan: begin
        cmd_o.scan = 1'b1;
      end
      CtrlFinish: begin
        cmd_o.finish = 1'b1;
      end
      default: begin
        busy_o = 1'b0;
      end
    endcase
  end

  a_finish_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> !cmd_o.finish && !busy_o)
    else $error("finish lasted more than one cycle");

  a_load_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> cmd_o.scan)
    else $error("scan did not follow load");

  a_scan_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.scan && stat_i.scan_end |=> cmd_o.finish)
    else $error("finish did not follow end of scan");

endmodule

// ===== hdl/sat_dp.sv =====
module sat_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sat_pkg::sat_cmd_t             cmd_i,
  input  logic [sat_pkg::ActionW-1:0]   action_i,
  input  logic [sat_pkg::AddrW-1:0]     mac_addr_i,
  output sat_pkg::sat_stat_t            stat_o,
  output logic                          hit_o,
  output logic [sat_pkg::SlotW-1:0]     slot_o,
  output logic [sat_pkg::StatusW-1:0]   status_o,
  output logic [sat_pkg::CountW-1:0]    station_count_o,
  output logic                          done_o
);
  import sat_pkg::*;

  logic [AddrW-1:0]       addr_mem [MaxStations];
  logic [MaxStations-1:0] entry_valid_q, entry_valid_d;
  logic [CntW-1:0]        count_q, count_d;
  logic [CntW-1:0]        scan_cnt_q;
  logic                   scan_end;
  logic [ActionW-1:0]     action_q;
  logic [AddrW-1:0]       addr_q;
  logic [AddrW-1:0]       rd_data_q;
  logic [IdxW-1:0]        rd_idx_q;
  logic                   rd_vld_q;
  logic                   match_found_q, free_found_q;
  logic [IdxW-1:0]        match_idx_q, free_idx_q;
  logic                   cmp_hit, cmp_free;
  logic                   mem_we;
  logic                   res_hit;
  logic [IdxW-1:0]        res_idx;
  status_e                res_status;
  logic                   hit_q;
  logic [SlotW-1:0]       slot_q;
  logic [StatusW-1:0]     status_q;
  logic                   done_q;

  assign scan_end      = (scan_cnt_q == CntW'(MaxStations));
  assign stat_o.scan_end = scan_end;

  // compare stage, one stored entry per cycle
  assign cmp_hit  = rd_vld_q && entry_valid_q[rd_idx_q] && (rd_data_q == addr_q);
  assign cmp_free = rd_vld_q && !entry_valid_q[rd_idx_q];

  // outcome of the transaction once the scan is done
  always_comb begin
    entry_valid_d = entry_valid_q;
    count_d       = count_q;
    mem_we        = 1'b0;
    res_hit       = match_found_q;
    res_idx       = match_found_q ? match_idx_q : '0;
    res_status    = match_found_q ? StFound : StNotFound;
    case (action_q)
      ActAdd: begin
        if (!match_found_q) begin
          if (free_found_q) begin
            mem_we                    = cmd_i.finish;
            entry_valid_d[free_idx_q] = 1'b1;
            count_d                   = count_q + CntW'(1);
            res_idx                   = free_idx_q;
            res_status                = StAdded;
          end else begin
            res_status = StFull;
          end
        end
      end
      ActRemove: begin
        if (match_found_q) begin
          entry_valid_d[match_idx_q] = 1'b0;
          if (count_q != '0) begin
            count_d = count_q - CntW'(1);
          end
          res_status = StRemoved;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_valid_q <= '0;
      count_q       <= '0;
      scan_cnt_q    <= '0;
      rd_vld_q      <= 1'b0;
      match_found_q <= 1'b0;
      free_found_q  <= 1'b0;
      done_q        <= 1'b0;
    end else begin
      done_q   <= cmd_i.finish;
      rd_vld_q <= cmd_i.scan && !scan_end;
      if (cmd_i.load) begin
        scan_cnt_q    <= '0;
        match_found_q <= 1'b0;
        free_found_q  <= 1'b0;
      end else if (cmd_i.scan && !scan_end) begin
        scan_cnt_q <= scan_cnt_q + CntW'(1);
      end
      if (cmp_hit && !match_found_q) begin
        match_found_q <= 1'b1;
      end
      if (cmp_free && !free_found_q) begin
        free_found_q <= 1'b1;
      end
      if (cmd_i.finish) begin
        entry_valid_q <= entry_valid_d;
        count_q       <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      action_q <= action_i;
      addr_q   <= mac_addr_i;
    end
    if (cmd_i.scan && !scan_end) begin
      rd_data_q <= addr_mem[scan_cnt_q[IdxW-1:0]];
      rd_idx_q  <= scan_cnt_q[IdxW-1:0];
    end
    if (mem_we) begin
      addr_mem[free_idx_q] <= addr_q;
    end
    if (cmp_hit && !match_found_q) begin
      match_idx_q <= rd_idx_q;
    end
    if (cmp_free && !free_found_q) begin
      free_idx_q <= rd_idx_q;
    end
    if (cmd_i.finish) begin
      hit_q    <= res_hit;
      slot_q   <= SlotW'(res_idx);
      status_q <= res_status;
    end
  end

  assign hit_o           = hit_q;
  assign slot_o          = slot_q;
  assign status_o        = status_q;
  assign station_count_o = CountW'(count_q);
  assign done_o          = done_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxStations))
    else $error("station count above table size");

  a_match_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish && match_found_q |-> entry_valid_q[match_idx_q])
    else $error("matched entry is not valid");

  a_free_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish && free_found_q |-> !entry_valid_q[free_idx_q])
    else $error("free entry is already valid");

  a_add_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish && mem_we |=> count_q == $past(count_q) + CntW'(1))
    else $error("add did not bump station count");

endmodule

// ===== hdl/station_address_table.sv =====
// Station table of up to 64 MAC addresses. Raise start with action_i and
// mac_addr_i while busy is low; the transaction is taken at that edge and
// busy stays high until the result is ready. Each transaction scans the
// address memory one entry per cycle; the result (done_o high for exactly
// one cycle with hit_o, slot_o, status_o and station_count_o) follows the
// scan state, the finish state and the result register. The receiver
// cannot stall: the result must be captured in its done_o cycle. A new
// transaction can be started in that same cycle but not before it, so
// transactions never overlap.
module station_address_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [sat_pkg::ActionW-1:0]   action_i,
  input  logic [sat_pkg::AddrW-1:0]     mac_addr_i,
  output logic                          done_o,
  output logic                          hit_o,
  output logic [sat_pkg::SlotW-1:0]     slot_o,
  output logic [sat_pkg::StatusW-1:0]   status_o,
  output logic [sat_pkg::CountW-1:0]    station_count_o
);
  import sat_pkg::*;

  sat_cmd_t  cmd;
  sat_stat_t stat;

  sat_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  sat_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .action_i       (action_i),
    .mac_addr_i     (mac_addr_i),
    .stat_o         (stat),
    .hit_o          (hit_o),
    .slot_o         (slot_o),
    .status_o       (status_o),
    .station_count_o(station_count_o),
    .done_o         (done_o)
  );

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while busy");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy && !done_o)
    else $error("busy not raised after accept");

endmodule

// ===== dv/tb_station_address_table.sv =====
module tb_station_address_table;
  import sat_pkg::*;

  localparam logic [ActionW-1:0] ActUnused = 2'd3;
  localparam logic [AddrW-1:0] AddrOnes = {AddrW{1'b1}};
  localparam logic [AddrW-1:0] AddrAlt1 = 48'hAAAA_AAAA_AAAA;
  localparam logic [AddrW-1:0] AddrAlt0 = 48'h5555_5555_5555;
  localparam logic [AddrW-1:0] AddrLsb = 48'h0000_0000_0001;
  localparam logic [AddrW-1:0] AddrMsb = 48'h8000_0000_0000;
  localparam int RandomItems = 1725;
  localparam int PoolSize = 96;
  localparam int PoolCap = 128;
  localparam int SettleCycles = 80;
  localparam int unsigned CycleLimit = 3000000;

  typedef enum int {
    PhFill,
    PhMix,
    PhDrain
  } phase_e;

  typedef struct packed {
    logic [ActionW-1:0] action;
    logic [AddrW-1:0]   mac;
  } station_req_t;

  typedef struct {
    logic                hit;
    logic [SlotW-1:0]    slot;
    status_e             status;
    logic [CountW-1:0]   count;
  } station_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [ActionW-1:0]  action_i = '0;
  logic [AddrW-1:0]    mac_addr_i = '0;
  logic                done_o;
  logic                hit_o;
  logic [SlotW-1:0]    slot_o;
  logic [StatusW-1:0]  status_o;
  logic [CountW-1:0]   station_count_o;

  station_req_t        pending_reqs[$];
  station_result_t     expected_results[$];
  logic [AddrW-1:0]    addr_pool[$];

  bit                  tbl_valid[MaxStations];
  logic [AddrW-1:0]    tbl_addr[MaxStations];
  int unsigned         tbl_count = 0;

  int unsigned         err_cnt = 0;
  int unsigned         result_idx = 0;
  int unsigned         cycle_cnt = 0;
  int unsigned         gap_left = 0;
  int unsigned         calm_left = 0;
  int                  random_items = 0;

  station_address_table dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .action_i        (action_i),
    .mac_addr_i      (mac_addr_i),
    .done_o          (done_o),
    .hit_o           (hit_o),
    .slot_o          (slot_o),
    .status_o        (status_o),
    .station_count_o (station_count_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  function automatic station_result_t predict_station_op(logic [ActionW-1:0] act,
                                                         logic [AddrW-1:0] mac);
    station_result_t res;
    int match_idx;
    int free_idx;
    match_idx = -1;
    free_idx = -1;
    for (int i = MaxStations - 1; i >= 0; i--) begin
      if (tbl_valid[i] && tbl_addr[i] == mac) match_idx = i;
      if (!tbl_valid[i]) free_idx = i;
    end
    res.hit = (match_idx >= 0);
    res.slot = (match_idx >= 0) ? SlotW'(match_idx) : '0;
    if (act == ActAdd) begin
      if (match_idx >= 0) begin
        res.status = StFound;
      end else if (free_idx < 0) begin
        res.status = StFull;
      end else begin
        tbl_valid[free_idx] = 1'b1;
        tbl_addr[free_idx] = mac;
        tbl_count++;
        res.slot = SlotW'(free_idx);
        res.status = StAdded;
      end
    end else if (act == ActRemove) begin
      if (match_idx >= 0) begin
        tbl_valid[match_idx] = 1'b0;
        if (tbl_count > 0) tbl_count--;
        res.status = StRemoved;
      end else begin
        res.status = StNotFound;
      end
    end else begin
      res.status = res.hit ? StFound : StNotFound;
    end
    res.count = CountW'(tbl_count);
    return res;
  endfunction

  function automatic logic [AddrW-1:0] random_mac();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[AddrW-1:0];
  endfunction

  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(8, 1);
    if (r < 97) return $urandom_range(80, 9);
    return $urandom_range(300, 81);
  endfunction

  task automatic push_req(logic [ActionW-1:0] act, logic [AddrW-1:0] mac);
    station_req_t req;
    req.action = act;
    req.mac = mac;
    pending_reqs.push_back(req);
  endtask

  task automatic gen_phase(phase_e kind, int n, int win);
    int unsigned r;
    int base;
    logic [ActionW-1:0] act;
    logic [AddrW-1:0] mac;
    base = $urandom_range(addr_pool.size() - 1);
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 3) begin
        act = ActUnused;
      end else if (kind == PhFill) begin
        act = (r < 80) ? ActAdd : (r < 95) ? ActLookup : ActRemove;
      end else if (kind == PhMix) begin
        act = (r < 40) ? ActAdd : (r < 70) ? ActLookup : ActRemove;
      end else begin
        act = (r < 90) ? ActRemove : ActLookup;
      end
      if (kind == PhDrain) begin
        mac = addr_pool[(base + k) % addr_pool.size()];
      end else if ($urandom_range(9) == 0) begin
        mac = random_mac();
        if (act == ActAdd && addr_pool.size() < PoolCap) addr_pool.push_back(mac);
      end else begin
        mac = addr_pool[$urandom_range(win - 1)];
      end
      push_req(act, mac);
      random_items++;
    end
  endtask

  // driver: one transaction per start/not-busy edge
  always @(posedge clk_i) begin
    station_req_t req;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_results.push_back(predict_station_op(action_i, mac_addr_i));
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          req = pending_reqs.pop_front();
          action_i <= req.action;
          mac_addr_i <= req.mac;
          start <= 1'b1;
          if (calm_left > 0) begin
            calm_left--;
            gap_left = 0;
          end else begin
            if ($urandom_range(19) == 0) calm_left = $urandom_range(60, 20);
            gap_left = draw_gap();
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    station_result_t exp_res;
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("result %0d with no transaction pending: hit %0d slot %0d status %0d count %0d",
                   result_idx, hit_o, slot_o, status_o, station_count_o);
      end else begin
        exp_res = expected_results.pop_front();
        if (hit_o !== exp_res.hit || slot_o !== exp_res.slot ||
            status_o !== exp_res.status || station_count_o !== exp_res.count) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("result %0d mismatch: exp hit %0d slot %0d status %0d count %0d, got hit %0d slot %0d status %0d count %0d",
                     result_idx, exp_res.hit, exp_res.slot, exp_res.status, exp_res.count,
                     hit_o, slot_o, status_o, station_count_o);
        end
      end
      result_idx++;
    end
  end

  initial begin
    wait (cycle_cnt >= CycleLimit);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    phase_e kind;
    int unsigned r;
    int win;
    // directed
    push_req(ActLookup, '0);
    push_req(ActRemove, AddrOnes);
    push_req(ActAdd, '0);
    push_req(ActAdd, AddrOnes);
    push_req(ActAdd, '0);
    push_req(ActLookup, AddrOnes);
    push_req(ActUnused, '0);
    push_req(ActUnused, AddrAlt1);
    push_req(ActAdd, AddrAlt1);
    push_req(ActAdd, AddrAlt0);
    push_req(ActRemove, '0);
    push_req(ActLookup, '0);
    push_req(ActRemove, '0);
    push_req(ActAdd, AddrLsb);
    push_req(ActAdd, AddrMsb);
    push_req(ActLookup, AddrMsb | AddrLsb);
    push_req(ActRemove, AddrOnes);
    push_req(ActAdd, AddrOnes);
    push_req(ActUnused, AddrOnes);
    push_req(ActRemove, AddrAlt1);
    push_req(ActRemove, AddrAlt0);
    push_req(ActRemove, AddrLsb);
    push_req(ActRemove, AddrMsb);
    push_req(ActRemove, AddrOnes);

    // address pool: extremes, near neighbors, random
    addr_pool.push_back('0);
    addr_pool.push_back(AddrOnes);
    addr_pool.push_back(AddrAlt1);
    addr_pool.push_back(AddrAlt0);
    addr_pool.push_back(AddrLsb);
    addr_pool.push_back(AddrMsb);
    for (int b = 0; b < AddrW; b += 5) addr_pool.push_back(AddrAlt1 ^ (AddrLsb << b));
    while (addr_pool.size() < PoolSize) addr_pool.push_back(random_mac());

    // first phase fills past capacity
    gen_phase(PhFill, 160, addr_pool.size());
    while (random_items < RandomItems) begin
      r = $urandom_range(99);
      kind = (r < 35) ? PhFill : (r < 80) ? PhMix : PhDrain;
      case ($urandom_range(4))
        0: win = 2;
        1: win = 8;
        2: win = 32;
        3: win = 64;
        default: win = addr_pool.size();
      endcase
      if (kind == PhDrain) gen_phase(kind, addr_pool.size(), win);
      else gen_phase(kind, $urandom_range(160, 40), win);
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() != 0 || start || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    if (err_cnt == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
